>>> design/mme_pkg.sv
// Shared constants, command codes and types of the matrix multiply engine.
package mme_pkg;

    localparam int MAX_DIM   = 8;
    localparam int DIM_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * DIM_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int DATA_W    = 32;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_START  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_OOB = 2'd1;
    localparam logic [ST_W-1:0] ST_DIM = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_B  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B  = 2'd3;

    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] K_NONE    = 3'd0;
    localparam logic [KIND_W-1:0] K_WR_A    = 3'd1;
    localparam logic [KIND_W-1:0] K_WR_B    = 3'd2;
    localparam logic [KIND_W-1:0] K_ERR_OOB = 3'd3;
    localparam logic [KIND_W-1:0] K_ERR_DIM = 3'd4;
    localparam logic [KIND_W-1:0] K_MULT    = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DIM_W-1:0]  row;
        logic [DIM_W-1:0]  col;
        logic [DATA_W-1:0] value;
        logic [DIM_W-1:0]  ra_m1;
        logic [DIM_W-1:0]  ia_m1;
        logic [DIM_W-1:0]  cb_m1;
    } t_cmd;

    function automatic logic [DIM_W-1:0] eff_dim_m1(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > CFG_W'(MAX_DIM)) begin
            res = DIM_W'(MAX_DIM - 1);
        end else begin
            res = DIM_W'(v - 1'b1);
        end
        return res;
    endfunction

endpackage

>>> design/mme_if.sv
// Item channel interfaces: load/start items in, product items out.
interface mme_in_if import mme_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          opcode;
    logic [DIM_W-1:0]         row_index;
    logic [DIM_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;

    modport source (output valid, opcode, row_index, col_index, element_value, input ready);
    modport sink   (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface mme_out_if import mme_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] product_value;
    logic [DIM_W-1:0]         out_row;
    logic [DIM_W-1:0]         out_col;
    logic [ST_W-1:0]          status;
    logic                     last;

    modport source (output valid, product_value, out_row, out_col, status, last, input ready);
    modport sink   (input valid, product_value, out_row, out_col, status, last, output ready);
endinterface

>>> design/mme_front.sv
// Front end: dimension registers, bounds and shape checks, command build.
module mme_front import mme_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    mme_in_if.sink               s_item,
    input  logic                 i_full,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [CFG_W-1:0] r_rows_a, r_inner_a, r_rows_b, r_cols_b;
    logic [DIM_W-1:0] w_ra, w_ia, w_rb, w_cb;
    logic [DIM_W-1:0] w_dr, w_dc;
    logic             w_oob;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a  <= CFG_W'(1);
            r_inner_a <= CFG_W'(1);
            r_rows_b  <= CFG_W'(1);
            r_cols_b  <= CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROWS_A:  r_rows_a  <= i_cfg_data;
                REG_INNER_A: r_inner_a <= i_cfg_data;
                REG_ROWS_B:  r_rows_b  <= i_cfg_data;
                REG_COLS_B:  r_cols_b  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_ra = eff_dim_m1(r_rows_a);
    assign w_ia = eff_dim_m1(r_inner_a);
    assign w_rb = eff_dim_m1(r_rows_b);
    assign w_cb = eff_dim_m1(r_cols_b);

    assign w_dr  = (s_item.opcode == OP_LOAD_A) ? w_ra : w_rb;
    assign w_dc  = (s_item.opcode == OP_LOAD_A) ? w_ia : w_cb;
    assign w_oob = (s_item.row_index > w_dr) || (s_item.col_index > w_dc);

    always_comb begin
        o_cmd.row   = s_item.row_index;
        o_cmd.col   = s_item.col_index;
        o_cmd.value = s_item.element_value;
        o_cmd.ra_m1 = w_ra;
        o_cmd.ia_m1 = w_ia;
        o_cmd.cb_m1 = w_cb;
        case (s_item.opcode)
            OP_LOAD_A: o_cmd.kind = w_oob ? K_ERR_OOB : K_WR_A;
            OP_LOAD_B: o_cmd.kind = w_oob ? K_ERR_OOB : K_WR_B;
            OP_START:  o_cmd.kind = (w_ia != w_rb) ? K_ERR_DIM : K_MULT;
            default:   o_cmd.kind = K_NONE;
        endcase
    end

    assign s_item.ready = !i_full;
    assign o_push       = s_item.valid && !i_full && (o_cmd.kind != K_NONE);

endmodule

>>> design/mme_queue.sv
// Short command queue between the front end and the multiply back end.
module mme_queue import mme_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              w_push, w_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> design/mme_back.sv
// Back end: element stores, multiply-accumulate sequencer and result register.
module mme_back import mme_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    mme_out_if.source m_res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ELEM  = 2'd1;
    localparam logic [1:0] S_RUN   = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [DATA_W-1:0] r_mem_a [DEPTH];
    logic [DATA_W-1:0] r_mem_b [DEPTH];
    logic [DATA_W-1:0] r_rd_a, r_rd_b;

    logic [1:0]        r_state, n_state;
    logic [DIM_W-1:0]  r_i, r_j, r_k, n_i, n_j, n_k;
    logic [DIM_W-1:0]  r_ra_m1, r_ia_m1, r_cb_m1;

    logic              r_s1_v, r_s1_first, r_s1_last;
    logic              r_s2_v, r_s2_first, r_s2_last;
    logic [DATA_W-1:0] r_prod, r_acc, w_sum;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic [DIM_W-1:0]  r_out_row, r_out_col;
    logic [ST_W-1:0]   r_out_status;
    logic              r_out_last;

    logic              w_out_free, w_is_err, w_done, w_last_elem;
    logic [ADDR_W-1:0] w_addr_a, w_addr_b, w_addr_wr;

    assign w_out_free  = !r_out_valid || m_res.ready;
    assign w_is_err    = (i_cmd.kind == K_ERR_OOB) || (i_cmd.kind == K_ERR_DIM);
    assign o_pop       = (r_state == S_IDLE) && i_cmd_valid && (!w_is_err || w_out_free);
    assign w_done      = r_s2_v && r_s2_last;
    assign w_last_elem = (r_i == r_ra_m1) && (r_j == r_cb_m1);

    assign w_addr_a  = {r_i, r_k};
    assign w_addr_b  = {r_k, r_j};
    assign w_addr_wr = {i_cmd.row, i_cmd.col};

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.kind == K_WR_A)) begin
            r_mem_a[w_addr_wr] <= i_cmd.value;
        end
        r_rd_a <= r_mem_a[w_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.kind == K_WR_B)) begin
            r_mem_b[w_addr_wr] <= i_cmd.value;
        end
        r_rd_b <= r_mem_b[w_addr_b];
    end

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        case (r_state)
            S_IDLE: begin
                if (o_pop && (i_cmd.kind == K_MULT)) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_state = S_ELEM;
                end
            end
            S_ELEM: begin
                if (w_out_free) begin
                    n_k     = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_k == r_ia_m1) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            S_DRAIN: begin
                if (w_done) begin
                    if (w_last_elem) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_ELEM;
                        if (r_j == r_cb_m1) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_s1_v  <= (r_state == S_RUN);
            r_s2_v  <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        if (o_pop && (i_cmd.kind == K_MULT)) begin
            r_ra_m1 <= i_cmd.ra_m1;
            r_ia_m1 <= i_cmd.ia_m1;
            r_cb_m1 <= i_cmd.cb_m1;
        end
        r_s1_first <= (r_k == '0);
        r_s1_last  <= (r_k == r_ia_m1);
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_prod     <= r_rd_a * r_rd_b;
        if (r_s2_v) begin
            r_acc <= w_sum;
        end
    end

    assign w_sum = (r_s2_first ? '0 : r_acc) + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done || (o_pop && w_is_err)) begin
            r_out_valid <= 1'b1;
        end else if (m_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_value  <= w_sum;
            r_out_row    <= r_i;
            r_out_col    <= r_j;
            r_out_status <= ST_OK;
            r_out_last   <= w_last_elem;
        end else if (o_pop && (i_cmd.kind == K_ERR_OOB)) begin
            r_out_value  <= '0;
            r_out_row    <= i_cmd.row;
            r_out_col    <= i_cmd.col;
            r_out_status <= ST_OOB;
            r_out_last   <= 1'b1;
        end else if (o_pop && (i_cmd.kind == K_ERR_DIM)) begin
            r_out_value  <= '0;
            r_out_row    <= '0;
            r_out_col    <= '0;
            r_out_status <= ST_DIM;
            r_out_last   <= 1'b1;
        end
    end

    assign m_res.valid         = r_out_valid;
    assign m_res.product_value = r_out_value;
    assign m_res.out_row       = r_out_row;
    assign m_res.out_col       = r_out_col;
    assign m_res.status        = r_out_status;
    assign m_res.last          = r_out_last;

endmodule

>>> design/matrix_multiply_engine.sv
// Top level of the integer matrix multiply engine.
//
//  channel   direction  handshake              payload
//  i_item    in         valid/ready            opcode, row_index, col_index, element_value
//  o_result  out        valid/ready            product_value, out_row, out_col, status, last
//  cfg       in         i_cfg_we, no stall     i_cfg_idx, i_cfg_data
//
// A load or start item is taken whenever the four-entry command queue has room.
// A load is written to its store at the edge at which it leaves the queue.
// Each product element passes through a setup state, one store read per term, then the
// multiplier and accumulator stages; a start takes rows_a * cols_b such elements.
// Reset clears the queue, the sequencer and the result register; the stores keep
// whatever they hold. A stalled result holds the back end; the front end keeps
// taking items until the queue fills.
module matrix_multiply_engine import mme_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    mme_in_if.sink               i_item,
    mme_out_if.source            o_result
);

    logic w_push, w_full, w_q_valid, w_pop;
    t_cmd w_push_cmd, w_q_cmd;

    mme_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_item     (i_item),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    mme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    mme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .m_res       (o_result)
    );

endmodule

>>> tb/sv/tb_top.sv
// Testbench of the matrix multiply engine: loads, multiplies and errors checked item by item.
module tb_top import mme_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int ITEM_TARGET = 220;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [DIM_W-1:0]  row;
        logic [DIM_W-1:0]  col;
        logic [DATA_W-1:0] value;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DIM_W-1:0]  row;
        logic [DIM_W-1:0]  col;
        logic [ST_W-1:0]   status;
        logic              last;
    } t_product;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    t_item                offer = '0;
    t_item                next_cmd;
    logic                 out_ready = 1'b0;

    t_item    cmd_q [$];
    t_product product_q [$];
    t_product want;

    logic [CFG_W-1:0]  dim_reg [4] = '{default: 4'd1};
    logic [DATA_W-1:0] left_mat [DEPTH];
    logic [DATA_W-1:0] right_mat [DEPTH];
    bit                left_set [DEPTH];
    bit                right_set [DEPTH];

    int idle_pct = 32;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int fail_cnt = 0;
    int gen_count = 0;
    int stall_cycles = 0;

    mme_in_if  cmd_if ();
    mme_out_if prod_if ();

    assign cmd_if.valid         = in_valid;
    assign cmd_if.opcode        = offer.opcode;
    assign cmd_if.row_index     = offer.row;
    assign cmd_if.col_index     = offer.col;
    assign cmd_if.element_value = offer.value;
    assign prod_if.ready        = out_ready;

    matrix_multiply_engine i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_item     (cmd_if.sink),
        .o_result   (prod_if.source)
    );

    always #2 clk = ~clk;

    function automatic int unsigned dim_eff(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > CFG_W'(MAX_DIM)) begin
            return MAX_DIM;
        end
        return v;
    endfunction

    function automatic void predict_products(input t_item c);
        int unsigned ra, ia, rb, cb, lim_r, lim_c, i, j, k;
        logic [DATA_W-1:0] acc;
        t_product p;
        ra = dim_eff(dim_reg[REG_ROWS_A]);
        ia = dim_eff(dim_reg[REG_INNER_A]);
        rb = dim_eff(dim_reg[REG_ROWS_B]);
        cb = dim_eff(dim_reg[REG_COLS_B]);
        case (c.opcode)
            OP_LOAD_A, OP_LOAD_B: begin
                lim_r = (c.opcode == OP_LOAD_A) ? ra : rb;
                lim_c = (c.opcode == OP_LOAD_A) ? ia : cb;
                if (c.row >= lim_r || c.col >= lim_c) begin
                    p = '{value: '0, row: c.row, col: c.col, status: ST_OOB, last: 1'b1};
                    product_q.push_back(p);
                end else if (c.opcode == OP_LOAD_A) begin
                    left_mat[{c.row, c.col}] = c.value;
                end else begin
                    right_mat[{c.row, c.col}] = c.value;
                end
            end
            OP_START: begin
                if (ia != rb) begin
                    p = '{value: '0, row: '0, col: '0, status: ST_DIM, last: 1'b1};
                    product_q.push_back(p);
                end else begin
                    for (i = 0; i < ra; i++) begin
                        for (j = 0; j < cb; j++) begin
                            acc = '0;
                            for (k = 0; k < ia; k++) begin
                                acc = acc + left_mat[i * MAX_DIM + k] * right_mat[k * MAX_DIM + j];
                            end
                            p.value  = acc;
                            p.row    = DIM_W'(i);
                            p.col    = DIM_W'(j);
                            p.status = ST_OK;
                            p.last   = (i + 1 == ra && j + 1 == cb);
                            product_q.push_back(p);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_v,
                                        input logic [DATA_W-1:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, got_v);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || cmd_if.ready) begin
            if (in_valid) begin
                predict_products(offer);
            end
            if (cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_cmd = cmd_q.pop_front();
                offer    <= next_cmd;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n && prod_if.valid && out_ready) begin
            if (product_q.size() == 0) begin
                $error("product item with none expected: value %0h row %0d col %0d status %0d",
                       prod_if.product_value, prod_if.out_row, prod_if.out_col, prod_if.status);
                fail_cnt++;
            end else begin
                want = product_q.pop_front();
                check_field("product_value", want.value, prod_if.product_value);
                check_field("out_row", DATA_W'(want.row), DATA_W'(prod_if.out_row));
                check_field("out_col", DATA_W'(want.col), DATA_W'(prod_if.out_col));
                check_field("status", DATA_W'(want.status), DATA_W'(prod_if.status));
                check_field("last", DATA_W'(want.last), DATA_W'(prod_if.last));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && cmd_if.ready) || (prod_if.valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [DATA_W-1:0] rand_value();
        if ($urandom_range(99) < 12) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return '1;
                default: return '0;
            endcase
        end
        return $urandom;
    endfunction

    function automatic logic [CFG_W-1:0] rand_dim();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 8) begin
            return '0;
        end
        if (p < 16) begin
            return CFG_W'($urandom_range(15, 9));
        end
        if (p < 26) begin
            return CFG_W'($urandom_range(8, 5));
        end
        return CFG_W'($urandom_range(4, 1));
    endfunction

    function automatic void push_cmd(input logic [OP_W-1:0] op, input int unsigned r,
                                     input int unsigned c, input logic [DATA_W-1:0] v);
        t_item item;
        item = '{opcode: op, row: DIM_W'(r), col: DIM_W'(c), value: v};
        if (op == OP_LOAD_A && r < dim_eff(dim_reg[REG_ROWS_A])
                && c < dim_eff(dim_reg[REG_INNER_A])) begin
            left_set[r * MAX_DIM + c] = 1'b1;
        end
        if (op == OP_LOAD_B && r < dim_eff(dim_reg[REG_ROWS_B])
                && c < dim_eff(dim_reg[REG_COLS_B])) begin
            right_set[r * MAX_DIM + c] = 1'b1;
        end
        if (op != OP_UNUSED) begin
            gen_count++;
        end
        cmd_q.push_back(item);
    endfunction

    task automatic wait_idle();
        while (cmd_q.size() != 0 || in_valid || product_q.size() != 0) begin
            @(negedge clk);
        end
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        dim_reg[idx] = val;
    endtask

    task automatic set_dims(input logic [CFG_W-1:0] ra, input logic [CFG_W-1:0] ia,
                            input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] cb);
        wait_idle();
        write_reg(REG_ROWS_A, ra);
        write_reg(REG_INNER_A, ia);
        write_reg(REG_ROWS_B, rb);
        write_reg(REG_COLS_B, cb);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_phase(input int n_extra);
        int unsigned ra, ia, rb, cb, r, c, p, lim_r, lim_c;
        logic [OP_W-1:0] op;
        ra = dim_eff(dim_reg[REG_ROWS_A]);
        ia = dim_eff(dim_reg[REG_INNER_A]);
        rb = dim_eff(dim_reg[REG_ROWS_B]);
        cb = dim_eff(dim_reg[REG_COLS_B]);
        for (r = 0; r < ra; r++) begin
            for (c = 0; c < ia; c++) begin
                if (!left_set[r * MAX_DIM + c]) begin
                    push_cmd(OP_LOAD_A, r, c, rand_value());
                end
            end
        end
        for (r = 0; r < rb; r++) begin
            for (c = 0; c < cb; c++) begin
                if (!right_set[r * MAX_DIM + c]) begin
                    push_cmd(OP_LOAD_B, r, c, rand_value());
                end
            end
        end
        repeat (n_extra) begin
            p = $urandom_range(99);
            op = (p < 47) ? OP_LOAD_A : (p < 94) ? OP_LOAD_B : OP_UNUSED;
            lim_r = (op == OP_LOAD_A) ? ra : rb;
            lim_c = (op == OP_LOAD_A) ? ia : cb;
            if ($urandom_range(99) < 75) begin
                r = $urandom_range(lim_r - 1);
                c = $urandom_range(lim_c - 1);
            end else begin
                r = $urandom_range(MAX_DIM - 1);
                c = $urandom_range(MAX_DIM - 1);
            end
            push_cmd(op, r, c, rand_value());
        end
        push_cmd(OP_START, $urandom_range(MAX_DIM - 1), $urandom_range(MAX_DIM - 1), $urandom);
    endtask

    initial begin
        int target;
        int phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_dims(4'd2, 4'd2, 4'd2, 4'd2);
        push_cmd(OP_LOAD_A, 0, 0, 32'h8000_0000);
        push_cmd(OP_LOAD_A, 0, 1, 32'h7FFF_FFFF);
        push_cmd(OP_LOAD_A, 1, 0, 32'hFFFF_FFFF);
        push_cmd(OP_LOAD_A, 1, 1, 32'h0000_0000);
        push_cmd(OP_LOAD_B, 0, 0, 32'h7FFF_FFFF);
        push_cmd(OP_LOAD_B, 0, 1, 32'h8000_0000);
        push_cmd(OP_LOAD_B, 1, 0, 32'h0000_0001);
        push_cmd(OP_LOAD_B, 1, 1, 32'hFFFF_FFFF);
        push_cmd(OP_LOAD_A, 2, 0, 32'h1234_5678);
        push_cmd(OP_LOAD_A, 0, 7, 32'h1234_5678);
        push_cmd(OP_LOAD_B, 7, 7, 32'hFFFF_FFFF);
        push_cmd(OP_UNUSED, 7, 7, 32'hFFFF_FFFF);
        push_cmd(OP_START, 0, 0, 32'h0);

        set_dims(4'd1, 4'd3, 4'd2, 4'd1);
        push_cmd(OP_START, 7, 7, 32'hFFFF_FFFF);

        set_dims(4'd0, 4'd15, 4'd15, 4'd0);
        load_phase(0);

        set_dims(4'd8, 4'd8, 4'd8, 4'd8);
        load_phase(0);

        wait_idle();
        hold_req++;
        push_cmd(OP_START, 0, 0, 32'h0);
        repeat (10) begin
            push_cmd($urandom_range(1) ? OP_LOAD_A : OP_LOAD_B, $urandom_range(MAX_DIM - 1),
                     $urandom_range(MAX_DIM - 1), rand_value());
        end
        push_cmd(OP_START, 0, 0, 32'h0);

        target = ITEM_TARGET;
        phase = 0;
        while (gen_count < target) begin
            idle_pct = (phase >= 3 && phase < 7) ? 0 : 32;
            set_dims(rand_dim(), rand_dim(), rand_dim(), rand_dim());
            if ($urandom_range(99) < 80) begin
                set_dims(dim_reg[REG_ROWS_A], dim_reg[REG_INNER_A], dim_reg[REG_INNER_A],
                         dim_reg[REG_COLS_B]);
            end
            load_phase($urandom_range(8));
            if ($urandom_range(99) < 20) begin
                set_dims(rand_dim(), dim_reg[REG_INNER_A], dim_reg[REG_INNER_A], rand_dim());
                load_phase(0);
            end
            phase++;
        end

        wait_idle();
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
